[design/tmte_pkg.sv]
package tmte_pkg;

  // Screen geometry and frame count.
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int FRAMES  = 8;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int LAST_ROW_BASE = COLUMNS * (ROWS - 1);

  // Derived widths.
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_RAW = $clog2(2 * COLUMNS + 1);
  localparam int CNT_W   = (CNT_RAW > 5) ? CNT_RAW : 5;

  // Field widths.
  localparam int CELL_W     = 16;
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = 11;
  localparam int TAB_W      = 5;
  localparam int CURSOR_W   = 14;
  localparam int START_W    = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Width of the read address sum before the ring correction.
  localparam int RD_BASE_W = (ADDR_W + 1 > IDX_W) ? ADDR_W + 1 : IDX_W;
  localparam int RD_W      = RD_BASE_W + 1;

  // Terminal byte codes.
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_ATTR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAB_WIDTH  = 2'd2;

  localparam logic [7:0]       TEXT_ATTR_RST  = 8'h0F;
  localparam logic [7:0]       CLEAR_ATTR_RST = 8'h07;
  localparam logic [TAB_W-1:0] TAB_WIDTH_RST  = 5'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic init_wr;
    logic decode;
    logic put;
    logic row_clear;
    logic latch;
    logic read_addr;
    logic read_mem;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic init_last;
    logic is_read;
    logic is_last;
    logic count_zero;
    logic col_zero;
    logic clr_last;
    logic out_busy;
  } status_t;

endpackage

[design/tmte_ctl.sv]
module tmte_ctl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tmte_pkg::status_t status,
  output tmte_pkg::cmd_t    cmd
);
  import tmte_pkg::*;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_COUNT,
    S_PUT,
    S_ROW,
    S_CLEAR,
    S_FINISH,
    S_RMEM,
    S_OUTPUT
  } state_t;

  state_t state;

  // Commands follow from the state and the datapath status.
  always_comb begin
    cmd = '0;
    case (state)
      S_INIT: begin
        cmd.init_wr = 1'b1;
      end
      S_IDLE: begin
        cmd.accept = in_valid && in_ready;
      end
      S_DECODE: begin
        if (status.is_read) begin
          cmd.read_addr = 1'b1;
        end else begin
          cmd.decode = 1'b1;
        end
      end
      S_PUT: begin
        cmd.put = 1'b1;
      end
      S_CLEAR: begin
        cmd.row_clear = 1'b1;
        cmd.latch     = status.clr_last;
      end
      S_FINISH: begin
        cmd.latch = status.is_last;
      end
      S_RMEM: begin
        cmd.read_mem = 1'b1;
      end
      S_OUTPUT: begin
        cmd.load_out = !status.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // State register and the registered ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      in_ready <= 1'b0;
    end else begin
      case (state)
        S_INIT: begin
          if (status.init_last) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= S_DECODE;
            in_ready <= 1'b0;
          end
        end
        S_DECODE: begin
          state <= status.is_read ? S_RMEM : S_COUNT;
        end
        S_COUNT: begin
          state <= status.count_zero ? S_FINISH : S_PUT;
        end
        S_PUT: begin
          state <= S_ROW;
        end
        S_ROW: begin
          if (status.col_zero) begin
            state <= S_CLEAR;
          end else if (status.count_zero) begin
            state <= S_FINISH;
          end else begin
            state <= S_PUT;
          end
        end
        S_CLEAR: begin
          if (status.clr_last) begin
            state <= S_COUNT;
          end
        end
        S_FINISH: begin
          state <= S_OUTPUT;
        end
        S_RMEM: begin
          state <= S_OUTPUT;
        end
        S_OUTPUT: begin
          if (!status.out_busy) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= S_INIT;
          in_ready <= 1'b0;
        end
      endcase
    end
  end

endmodule

[design/tmte_dp.sv]
module tmte_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tmte_pkg::cmd_t                       cmd,
  output tmte_pkg::status_t                    status,
  input  logic                                 cfg_we,
  input  logic [tmte_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tmte_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 req_type,
  input  logic [tmte_pkg::CHAR_W-1:0]          char_byte,
  input  logic                                 last_of_write,
  input  logic [tmte_pkg::IDX_W-1:0]           cell_index,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [tmte_pkg::CELL_W-1:0]          cell_data,
  output logic [tmte_pkg::CURSOR_W-1:0]        cursor_address,
  output logic [tmte_pkg::START_W-1:0]         start_address_high,
  output logic                                 scrolling_active
);
  import tmte_pkg::*;

  typedef enum logic [2:0] {
    CLS_PRINT,
    CLS_BS,
    CLS_TAB,
    CLS_LF,
    CLS_VT,
    CLS_HOME,
    CLS_SKIP
  } byte_class_t;

  // Configuration registers.
  logic [7:0]       text_attr;
  logic [7:0]       clear_attr;
  logic [TAB_W-1:0] tab_width;

  // Captured request.
  logic              req;
  logic [CHAR_W-1:0] ch;
  logic              last;
  logic [IDX_W-1:0]  idx;

  // Terminal state.
  logic [ADDR_W-1:0]   pos;
  logic [ADDR_W-1:0]   rowbase;
  logic [COL_W-1:0]    col;
  logic                wrapped;
  logic [FRAME_W-1:0]  frame;
  logic [CURSOR_W-1:0] cursor_reg;
  logic [START_W-1:0]  start_reg;

  // Sequencing counters.
  logic [CNT_W-1:0]  count;
  logic [CHAR_W-1:0] put_char;
  logic [COL_W-1:0]  clr_idx;
  logic [ADDR_W-1:0] init_addr;

  // Cell store and its ports.
  logic [CELL_W-1:0] mem [CELLS];
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic [ADDR_W-1:0] raddr;
  logic              idx_ok;
  logic [CELL_W-1:0] rd_data;

  byte_class_t        cls;
  logic               bs_move;
  logic               pos_last;
  logic [FRAME_W-1:0] frame_next;
  logic [ADDR_W-1:0]  off;
  logic [RD_W-1:0]    rd_base;
  logic [RD_W-1:0]    rd_sum;

  // Byte classification; bytes with the top bit set are ignored.
  always_comb begin
    if (!ch[CHAR_W-1] && ch >= CH_SPACE) begin
      cls = CLS_PRINT;
    end else begin
      case (ch)
        CH_BS:   cls = CLS_BS;
        CH_TAB:  cls = CLS_TAB;
        CH_LF:   cls = CLS_LF;
        CH_VT:   cls = CLS_VT;
        CH_FF:   cls = CLS_HOME;
        default: cls = CLS_SKIP;
      endcase
    end
  end

  assign bs_move  = cmd.decode && (cls == CLS_BS) && (pos != '0);
  assign pos_last = (pos == ADDR_W'(CELLS - 1));

  // Status toward the controller.
  assign status.init_last  = (init_addr == ADDR_W'(CELLS - 1));
  assign status.is_read    = req;
  assign status.is_last    = last;
  assign status.count_zero = (count == '0);
  assign status.col_zero   = (col == '0);
  assign status.clr_last   = (clr_idx == COL_W'(COLUMNS - 1));
  assign status.out_busy   = out_valid && !out_ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr  <= TEXT_ATTR_RST;
      clear_attr <= CLEAR_ATTR_RST;
      tab_width  <= TAB_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEXT_ATTR:  text_attr  <= cfg_data;
        CFG_CLEAR_ATTR: clear_attr <= cfg_data;
        CFG_TAB_WIDTH:  tab_width  <= cfg_data[TAB_W-1:0];
        default: ;
      endcase
    end
  end

  // Request capture on an accepted beat.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req  <= req_type;
      ch   <= char_byte;
      last <= last_of_write;
      idx  <= cell_index;
    end
  end

  // Cell count and character for the put loop.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      put_char <= CH_SPACE;
    end else if (cmd.decode) begin
      put_char <= CH_SPACE;
      case (cls)
        CLS_PRINT: begin
          count    <= CNT_W'(1);
          put_char <= ch;
        end
        CLS_TAB: count <= CNT_W'(tab_width);
        CLS_LF:  count <= CNT_W'(COLUMNS) - CNT_W'(col);
        CLS_VT:  count <= CNT_W'(2 * COLUMNS);
        default: count <= '0;
      endcase
    end else if (cmd.put) begin
      count <= count - 1'b1;
    end
  end

  // Write position, column, row start and wrap flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      col     <= '0;
      rowbase <= '0;
      wrapped <= 1'b0;
    end else if (cmd.put) begin
      pos <= pos_last ? '0 : pos + 1'b1;
      if (pos_last) begin
        wrapped <= 1'b1;
      end
      if (col == COL_W'(COLUMNS - 1)) begin
        col     <= '0;
        rowbase <= pos_last ? '0 : rowbase + ADDR_W'(COLUMNS);
      end else begin
        col <= col + 1'b1;
      end
    end else if (bs_move) begin
      pos <= pos - 1'b1;
      if (col == '0) begin
        col     <= COL_W'(COLUMNS - 1);
        rowbase <= rowbase - ADDR_W'(COLUMNS);
      end else begin
        col <= col - 1'b1;
      end
    end else if (cmd.decode && cls == CLS_HOME) begin
      pos <= rowbase;
      col <= '0;
    end
  end

  // Reset sweep and row clear counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      init_addr <= '0;
      clr_idx   <= '0;
    end else begin
      if (cmd.init_wr) begin
        init_addr <= init_addr + 1'b1;
      end
      if (cmd.row_clear) begin
        clr_idx <= status.clr_last ? '0 : clr_idx + 1'b1;
      end
    end
  end

  // Frame advance and CRT register latch.
  assign frame_next = (frame == FRAME_W'(FRAMES - 1)) ? '0 : frame + 1'b1;
  assign off = wrapped ? ADDR_W'(LAST_ROW_BASE) + ADDR_W'(col) : pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame      <= '0;
      start_reg  <= '0;
      cursor_reg <= '0;
    end else if (cmd.latch) begin
      frame      <= frame_next;
      start_reg  <= START_W'({frame_next, 3'b000});
      cursor_reg <= CURSOR_W'({frame_next, 11'b0}) + CURSOR_W'(off);
    end
  end

  // Single write port shared by the sweep, puts, row clears and backspace.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = {text_attr, put_char};
    if (cmd.init_wr) begin
      wr_en   = 1'b1;
      wr_addr = init_addr;
      wr_data = RESET_CELL;
    end else if (cmd.put) begin
      wr_en = 1'b1;
    end else if (cmd.row_clear) begin
      wr_en   = 1'b1;
      wr_addr = rowbase + ADDR_W'(clr_idx);
      wr_data = {clear_attr, CH_SPACE};
    end else if (bs_move) begin
      wr_en   = 1'b1;
      wr_addr = pos - 1'b1;
      wr_data = {text_attr, CH_SPACE};
    end
  end

  // Displayed cell to store address; the oldest row comes first once wrapped.
  assign rd_base = wrapped ? RD_W'(rowbase) + RD_W'(COLUMNS) : '0;
  assign rd_sum  = rd_base + RD_W'(idx);

  always_ff @(posedge clk) begin
    if (cmd.read_addr) begin
      idx_ok <= (RD_W'(idx) < RD_W'(CELLS));
      if (RD_W'(idx) >= RD_W'(CELLS)) begin
        raddr <= '0;
      end else if (rd_sum >= RD_W'(CELLS)) begin
        raddr <= ADDR_W'(rd_sum - RD_W'(CELLS));
      end else begin
        raddr <= ADDR_W'(rd_sum);
      end
    end
  end

  // Cell store.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_mem) begin
      rd_data <= mem[raddr];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      cell_data          <= (req && idx_ok) ? rd_data : '0;
      cursor_address     <= cursor_reg;
      start_address_high <= start_reg;
      scrolling_active   <= wrapped;
    end
  end

  // The row start and column always add up to the write position.
  a_pos_split: assert property (@(posedge clk) disable iff (rst)
    rowbase + ADDR_W'(col) == pos)
    else $error("row start plus column differs from write position");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    int'(col) < COLUMNS)
    else $error("column out of range");

  a_start_frame: assert property (@(posedge clk) disable iff (rst)
    cmd.latch |=> start_reg == START_W'({frame, 3'b000}))
    else $error("start register does not follow the frame");

  a_wrap_sticky: assert property (@(posedge clk) disable iff (rst)
    wrapped |=> wrapped)
    else $error("wrap flag cleared outside reset");

endmodule

[design/text_mode_terminal_engine_core.sv]
// A printable byte goes through decode, count, put, row and finish; a read through decode
// and a store read. The put loop writes blank fills one cell at a time, and each finished
// row is followed by a clear of the row after it, all through the single write port.
// Throughput: one item at a time; the next item is accepted once the result is loaded.
// Reset: control state clears at once, then a sweep writes 0x0720 to all CELLS (2000)
// cells while in_ready stays low; configuration writes are taken meanwhile.
module text_mode_terminal_engine_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [tmte_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tmte_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 req_type,
  input  logic [tmte_pkg::CHAR_W-1:0]          char_byte,
  input  logic                                 last_of_write,
  input  logic [tmte_pkg::IDX_W-1:0]           cell_index,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [tmte_pkg::CELL_W-1:0]          cell_data,
  output logic [tmte_pkg::CURSOR_W-1:0]        cursor_address,
  output logic [tmte_pkg::START_W-1:0]         start_address_high,
  output logic                                 scrolling_active
);
  import tmte_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  tmte_ctl u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Cell store, position logic and output register.
  tmte_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .req_type           (req_type),
    .char_byte          (char_byte),
    .last_of_write      (last_of_write),
    .cell_index         (cell_index),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .cell_data          (cell_data),
    .cursor_address     (cursor_address),
    .start_address_high (start_address_high),
    .scrolling_active   (scrolling_active)
  );

endmodule
